/* hw/rtl/assert_macros.svh */
// assertion macros used by the tour sequencer module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_PROP(lbl, clk, rst, !(cond), msg)

`endif

/* hw/rtl/nnt_pkg.sv */
// shared constants and types of the nearest-neighbor tour builder
package nnt_pkg;

   // sizing
   localparam int MAX_CITIES = 32;
   localparam int DIST_BITS  = 16;
   localparam int CITY_BITS  = $clog2(MAX_CITIES);
   localparam int CNT_BITS   = $clog2(MAX_CITIES + 1);
   localparam int ADDR_BITS  = 2 * CITY_BITS;
   localparam int MEM_DEPTH  = 1 << ADDR_BITS;

   // result field widths
   localparam int EDGE_BITS = 16;
   localparam int TOUR_BITS = 21;
   localparam int SUM_BITS  = ((TOUR_BITS > DIST_BITS) ? TOUR_BITS : DIST_BITS) + 1;
   localparam logic [TOUR_BITS-1:0] TOUR_MAX = '1;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   // register indexes
   localparam logic CSR_CITY_COUNT = 1'b0;
   localparam logic CSR_START_CITY = 1'b1;

   // one tour entry handed from the sequencer to the result register
   typedef struct packed {
      logic [CITY_BITS-1:0] position;
      logic [CITY_BITS-1:0] city;
      logic [DIST_BITS-1:0] edge_len;
      logic                 last;
   } emit_type;

endpackage

/* hw/rtl/nnt_dist_mem.sv */
// distance matrix memory, one write and one registered read port
module nnt_dist_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [nnt_pkg::ADDR_BITS-1:0] wr_addr,
   input  logic [nnt_pkg::DIST_BITS-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [nnt_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [nnt_pkg::DIST_BITS-1:0] rd_data
);
   import nnt_pkg::*;

   logic [DIST_BITS-1:0] dist_mem_ff [0:MEM_DEPTH-1];
   logic [DIST_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= dist_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nnt_tour_seq.sv */
// tour sequencer: scans one matrix row per step and picks the nearest unvisited city
`include "assert_macros.svh"

module nnt_tour_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          run_go,
   input  logic [nnt_pkg::CNT_BITS-1:0]  city_count,
   input  logic [nnt_pkg::CITY_BITS-1:0] start_city,
   output logic                          idle,
   output logic                          rd_en,
   output logic [nnt_pkg::ADDR_BITS-1:0] rd_addr,
   input  logic [nnt_pkg::DIST_BITS-1:0] rd_data,
   output logic                          emit_valid,
   output nnt_pkg::emit_type             emit,
   input  logic                          emit_ready
);
   import nnt_pkg::*;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_SCAN       = 3'd1;
   localparam logic [2:0] ST_DRAIN      = 3'd2;
   localparam logic [2:0] ST_STEP       = 3'd3;
   localparam logic [2:0] ST_FINAL_RD   = 3'd4;
   localparam logic [2:0] ST_FINAL_WAIT = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   n_ff, n_in;
   logic [CITY_BITS-1:0]  start_ff, start_in;
   logic [CITY_BITS-1:0]  cur_ff, cur_in;
   logic [CNT_BITS-1:0]   j_ff, j_in;
   logic [CNT_BITS-1:0]   pos_ff, pos_in;
   logic [MAX_CITIES-1:0] visited_ff, visited_in;
   logic [DIST_BITS-1:0]  best_ff, best_in;
   logic [CITY_BITS-1:0]  pick_ff, pick_in;
   logic                  found_ff, found_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [CITY_BITS-1:0]  rd_j_ff, rd_j_in;
   logic [CNT_BITS-1:0]   n_clamp;

   // clamp the configured count into the supported range
   always_comb begin
      if (city_count < CNT_BITS'(2)) begin
         n_clamp = CNT_BITS'(2);
      end else if (city_count > CNT_BITS'(MAX_CITIES)) begin
         n_clamp = CNT_BITS'(MAX_CITIES);
      end else begin
         n_clamp = city_count;
      end
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      start_in   = start_ff;
      cur_in     = cur_ff;
      j_in       = j_ff;
      pos_in     = pos_ff;
      visited_in = visited_ff;
      best_in    = best_ff;
      pick_in    = pick_ff;
      found_in   = found_ff;
      rd_vld_in  = 1'b0;
      rd_j_in    = rd_j_ff;
      rd_en      = 1'b0;
      rd_addr    = {cur_ff, j_ff[CITY_BITS-1:0]};
      emit_valid = 1'b0;
      emit       = '{position: CITY_BITS'(pos_ff - CNT_BITS'(1)), city: cur_ff,
                     edge_len: best_ff, last: 1'b0};

      // compare the row entry that returned from memory
      if (rd_vld_ff && !visited_ff[rd_j_ff] && (!found_ff || rd_data < best_ff)) begin
         best_in  = rd_data;
         pick_in  = rd_j_ff;
         found_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (run_go) begin
               n_in       = n_clamp;
               start_in   = (CNT_BITS'(start_city) < n_clamp) ? start_city : '0;
               cur_in     = start_in;
               visited_in = '0;
               visited_in[start_in] = 1'b1;
               pos_in     = CNT_BITS'(1);
               j_in       = '0;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en     = 1'b1;
            rd_vld_in = 1'b1;
            rd_j_in   = j_ff[CITY_BITS-1:0];
            j_in      = j_ff + CNT_BITS'(1);
            if (j_ff == n_ff - CNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               visited_in[pick_ff] = 1'b1;
               cur_in   = pick_ff;
               pos_in   = pos_ff + CNT_BITS'(1);
               j_in     = '0;
               found_in = 1'b0;
               state_in = (pos_ff == n_ff - CNT_BITS'(1)) ? ST_FINAL_RD : ST_SCAN;
            end
         end
         ST_FINAL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = {cur_ff, start_ff};
            state_in = ST_FINAL_WAIT;
         end
         ST_FINAL_WAIT: begin
            emit_valid = 1'b1;
            emit       = '{position: CITY_BITS'(n_ff - CNT_BITS'(1)), city: cur_ff,
                           edge_len: rd_data, last: 1'b1};
            if (emit_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         n_ff       <= CNT_BITS'(2);
         start_ff   <= '0;
         cur_ff     <= '0;
         j_ff       <= '0;
         pos_ff     <= '0;
         visited_ff <= '0;
         found_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         n_ff       <= n_in;
         start_ff   <= start_in;
         cur_ff     <= cur_in;
         j_ff       <= j_in;
         pos_ff     <= pos_in;
         visited_ff <= visited_in;
         found_ff   <= found_in;
         rd_vld_ff  <= rd_vld_in;
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      best_ff <= best_in;
      pick_ff <= pick_in;
      rd_j_ff <= rd_j_in;
   end

   assign idle = (state_ff == ST_IDLE);

   // checks
   `ASSERT_PROP(a_cur_visited, clock, reset,
      state_ff != ST_IDLE |-> visited_ff[cur_ff], "current city is not marked visited")
   `ASSERT_PROP(a_marks_match_pos, clock, reset,
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> $countones(visited_ff) == pos_ff,
      "visited marks disagree with placed city count")
   `ASSERT_PROP(a_pick_fresh, clock, reset,
      state_ff == ST_STEP |-> found_ff && !visited_ff[pick_ff],
      "step chose no city or a visited city")
   `ASSERT_PROP(a_step_marks_one, clock, reset,
      (state_ff == ST_STEP && emit_ready) |=>
         $countones(visited_ff) == $countones($past(visited_ff)) + 1,
      "step did not mark exactly one new city")

endmodule

/* hw/rtl/nnt_rsp_reg.sv */
// result register with running tour length
module nnt_rsp_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          emit_valid,
   input  nnt_pkg::emit_type             emit,
   output logic                          emit_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nnt_pkg::CITY_BITS-1:0] rsp_position,
   output logic [nnt_pkg::CITY_BITS-1:0] rsp_city,
   output logic [nnt_pkg::EDGE_BITS-1:0] rsp_edge_length,
   output logic [nnt_pkg::TOUR_BITS-1:0] rsp_tour_length,
   output logic                          rsp_last
);
   import nnt_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TOUR_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS-1:0]  sum_wide;
   logic [CITY_BITS-1:0] position_ff;
   logic [CITY_BITS-1:0] city_ff;
   logic [EDGE_BITS-1:0] edge_ff;
   logic [TOUR_BITS-1:0] tour_ff;
   logic                 last_ff;
   logic                 load;

   assign emit_ready = !valid_ff || rsp_ready;
   assign load       = emit_valid && emit_ready;

   // saturating tour sum, restarted at the first position
   always_comb begin
      sum_wide = SUM_BITS'(sum_ff) + SUM_BITS'(emit.edge_len);
      if (emit.position == '0) begin
         sum_wide = SUM_BITS'(emit.edge_len);
      end
      if (sum_wide > SUM_BITS'(TOUR_MAX)) begin
         sum_in = TOUR_MAX;
      end else begin
         sum_in = sum_wide[TOUR_BITS-1:0];
      end
   end

   // valid flag
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff      <= sum_in;
         position_ff <= emit.position;
         city_ff     <= emit.city;
         edge_ff     <= EDGE_BITS'(emit.edge_len);
         tour_ff     <= emit.last ? sum_in : '0;
         last_ff     <= emit.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_position    = position_ff;
   assign rsp_city        = city_ff;
   assign rsp_edge_length = edge_ff;
   assign rsp_tour_length = tour_ff;
   assign rsp_last        = last_ff;

endmodule

/* hw/rtl/nearest_neighbour_tour.sv */
// Greedy nearest-neighbor tour builder over a loaded distance matrix.
// Load transactions write one matrix entry each; one is taken every cycle while idle.
// During a run, each step reads one matrix row from the distance memory, then compares
// and moves to the nearest unvisited city; a final read fetches the closing edge.
// Reset clears the registers (city_count 2, start_city 0) and the sequencer;
// the distance memory is not cleared and holds no defined data until loaded.
module nearest_neighbour_tour (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [nnt_pkg::CNT_BITS-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [nnt_pkg::CITY_BITS-1:0] req_row,
   input  logic [nnt_pkg::CITY_BITS-1:0] req_col,
   input  logic [nnt_pkg::DIST_BITS-1:0] req_distance,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nnt_pkg::CITY_BITS-1:0] rsp_position,
   output logic [nnt_pkg::CITY_BITS-1:0] rsp_city,
   output logic [nnt_pkg::EDGE_BITS-1:0] rsp_edge_length,
   output logic [nnt_pkg::TOUR_BITS-1:0] rsp_tour_length,
   output logic                          rsp_last
);
   import nnt_pkg::*;

   logic [CNT_BITS-1:0]  city_count_ff;
   logic [CITY_BITS-1:0] start_city_ff;
   logic                 seq_idle;
   logic                 req_take;
   logic                 run_go;
   logic                 wr_en;
   logic                 rd_en;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [DIST_BITS-1:0] rd_data;
   logic                 emit_valid;
   logic                 emit_ready;
   emit_type             emit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CNT_BITS'(2);
         start_city_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CITY_COUNT: city_count_ff <= csr_wdata;
            CSR_START_CITY: start_city_ff <= csr_wdata[CITY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // request decode
   assign req_ready = seq_idle;
   assign req_take  = req_valid && req_ready;
   assign run_go    = req_take && (req_cmd == CMD_RUN);
   assign wr_en     = req_take && (req_cmd == CMD_LOAD)
                      && (CNT_BITS'(req_row) < CNT_BITS'(MAX_CITIES))
                      && (CNT_BITS'(req_col) < CNT_BITS'(MAX_CITIES));

   nnt_dist_mem u_dist_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_distance),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nnt_tour_seq u_tour_seq (
      .clock      (clock),
      .reset      (reset),
      .run_go     (run_go),
      .city_count (city_count_ff),
      .start_city (start_city_ff),
      .idle       (seq_idle),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .emit_valid (emit_valid),
      .emit       (emit),
      .emit_ready (emit_ready)
   );

   nnt_rsp_reg u_rsp_reg (
      .clock           (clock),
      .reset           (reset),
      .emit_valid      (emit_valid),
      .emit            (emit),
      .emit_ready      (emit_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_city        (rsp_city),
      .rsp_edge_length (rsp_edge_length),
      .rsp_tour_length (rsp_tour_length),
      .rsp_last        (rsp_last)
   );

endmodule

/* dv/tb_nearest_neighbour_tour.sv */
// self-checking testbench of the nearest-neighbor tour builder with its own greedy tour predictor
module tb_nearest_neighbour_tour;
   timeunit 1ns;
   timeprecision 1ps;

   import nnt_pkg::*;

   localparam int TOTAL_ITEMS  = 400;
   localparam int BUSY_PCT     = 72;
   localparam int LIGHT_PCT    = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 1000000;

   // hand-built 4 city matrix: three-way tie out of city 0, zero and full-scale edges
   localparam logic [DIST_BITS-1:0] DIRECTED_DIST [16] = '{
      16'h0000, 16'h0007, 16'h0007, 16'h0007,
      16'hFFFF, 16'h0000, 16'h0005, 16'h0000,
      16'hFFFF, 16'h0001, 16'h0000, 16'h0009,
      16'h0003, 16'h0004, 16'h0002, 16'h0000
   };

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic                 cmd;
      logic [CITY_BITS-1:0] row;
      logic [CITY_BITS-1:0] col;
      logic [DIST_BITS-1:0] distance;
   } matrix_op_type;

   typedef struct {
      logic [CITY_BITS-1:0] position;
      logic [CITY_BITS-1:0] city;
      logic [EDGE_BITS-1:0] edge_len;
      logic [TOUR_BITS-1:0] tour_len;
      logic                 last;
   } tour_stop_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic                 csr_index = CSR_CITY_COUNT;
   logic [CNT_BITS-1:0]  csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = CMD_LOAD;
   logic [CITY_BITS-1:0] req_row = '0;
   logic [CITY_BITS-1:0] req_col = '0;
   logic [DIST_BITS-1:0] req_distance = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CITY_BITS-1:0] rsp_position;
   logic [CITY_BITS-1:0] rsp_city;
   logic [EDGE_BITS-1:0] rsp_edge_length;
   logic [TOUR_BITS-1:0] rsp_tour_length;
   logic                 rsp_last;

   // predictor state: matrix copy, which entries were written, register copies
   logic [DIST_BITS-1:0] dist_copy [MAX_CITIES][MAX_CITIES];
   bit                   loaded [MAX_CITIES][MAX_CITIES];
   logic [CNT_BITS-1:0]  cfg_count = CNT_BITS'(2);
   logic [CITY_BITS-1:0] cfg_start = '0;

   matrix_op_type pending_ops [$];
   tour_stop_type tour_stops_due [$];
   idle_mode_type idle_mode = IDLE_NONE;

   int queued_count = 0;
   int accepted_count = 0;
   int loads_accepted = 0;
   int tours_accepted = 0;
   int stops_checked = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_requests = 0;
   int stall_served = 0;
   int hold_left = 0;

   nearest_neighbour_tour uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_distance    (req_distance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_city        (rsp_city),
      .rsp_edge_length (rsp_edge_length),
      .rsp_tour_length (rsp_tour_length),
      .rsp_last        (rsp_last)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // count register clamped to the supported range
   function automatic int used_cities(logic [CNT_BITS-1:0] value);
      if (value < 2) return 2;
      if (value > MAX_CITIES) return MAX_CITIES;
      return int'(value);
   endfunction

   // greedy tour from the current matrix copy, one stop per position
   function automatic void greedy_tour();
      int n;
      int origin;
      int here;
      int pick;
      int nxt;
      bit found;
      bit [MAX_CITIES-1:0] seen;
      int order [MAX_CITIES];
      logic [DIST_BITS-1:0] best;
      logic [SUM_BITS-1:0] total;
      tour_stop_type stop;
      n = used_cities(cfg_count);
      origin = (cfg_start >= n) ? 0 : int'(cfg_start);
      seen = '0;
      seen[origin] = 1'b1;
      order[0] = origin;
      here = origin;
      for (int pos = 1; pos < n; pos++) begin
         found = 1'b0;
         best = '0;
         pick = 0;
         // strictly smaller wins, so the lowest index keeps a tie
         for (int j = 0; j < n; j++) begin
            if (!seen[j] && (!found || dist_copy[here][j] < best)) begin
               found = 1'b1;
               best = dist_copy[here][j];
               pick = j;
            end
         end
         seen[pick] = 1'b1;
         order[pos] = pick;
         here = pick;
      end
      // edges including the closing one, running total saturates
      total = '0;
      for (int pos = 0; pos < n; pos++) begin
         nxt = (pos + 1 < n) ? order[pos + 1] : order[0];
         total = total + SUM_BITS'(dist_copy[order[pos]][nxt]);
         if (total > SUM_BITS'(TOUR_MAX)) total = SUM_BITS'(TOUR_MAX);
         stop.position = CITY_BITS'(pos);
         stop.city = CITY_BITS'(order[pos]);
         stop.edge_len = dist_copy[order[pos]][nxt];
         stop.last = (pos == n - 1);
         stop.tour_len = stop.last ? total[TOUR_BITS-1:0] : '0;
         tour_stops_due.insert(tour_stops_due.size(), stop);
      end
   endfunction

   function automatic bit sender_waits();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < BUSY_PCT;
         IDLE_BOTH:   return $urandom_range(0, 99) < LIGHT_PCT;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_waits();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < BUSY_PCT;
         IDLE_BOTH:     return $urandom_range(0, 99) < LIGHT_PCT;
         default:       return 1'b0;
      endcase
   endfunction

   // mostly full-range values, with zeros, full scale and near ties mixed in
   function automatic logic [DIST_BITS-1:0] random_distance();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return DIST_BITS'($urandom_range(0, 3));
         default: return DIST_BITS'($urandom);
      endcase
   endfunction

   // one line per mismatch, and count it
   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      matrix_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // transaction accepted: update the predictor
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_LOAD) begin
               dist_copy[req_row][req_col] = req_distance;
               loads_accepted++;
            end else begin
               greedy_tour();
               tours_accepted++;
            end
            accepted_count++;
         end
         // offer the next item unless one is still waiting
         if (!req_valid || req_ready) begin
            if (pending_ops.size() != 0 && !sender_waits()) begin
               op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_cmd <= op.cmd;
               req_row <= op.row;
               req_col <= op.col;
               req_distance <= op.distance;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result ready, with random stalls and requested long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_requests != stall_served) begin
         stall_served++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !receiver_waits();
      end
   end

   // result checker
   always @(posedge clock) begin : check_rsp
      tour_stop_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tour_stops_due.size() == 0) begin
            flag_mismatch("result with nothing expected, city", 32'(rsp_city), '0);
         end else begin
            want = tour_stops_due.pop_front();
            if (rsp_position !== want.position)
               flag_mismatch("position", 32'(rsp_position), 32'(want.position));
            if (rsp_city !== want.city)
               flag_mismatch("city", 32'(rsp_city), 32'(want.city));
            if (rsp_edge_length !== want.edge_len)
               flag_mismatch("edge_length", 32'(rsp_edge_length), 32'(want.edge_len));
            if (rsp_tour_length !== want.tour_len)
               flag_mismatch("tour_length", 32'(rsp_tour_length), 32'(want.tour_len));
            if (rsp_last !== want.last)
               flag_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
         stops_checked++;
      end
   end

   task automatic write_csr(logic idx, logic [CNT_BITS-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CITY_COUNT) cfg_count = value;
      else cfg_start = value[CITY_BITS-1:0];
   endtask

   task automatic queue_load(logic [CITY_BITS-1:0] r, logic [CITY_BITS-1:0] c,
                             logic [DIST_BITS-1:0] d);
      matrix_op_type op;
      op.cmd = CMD_LOAD;
      op.row = r;
      op.col = c;
      op.distance = d;
      pending_ops.insert(pending_ops.size(), op);
      loaded[r][c] = 1'b1;
      queued_count++;
   endtask

   // tour request, preceded by loads of any active entry never written
   task automatic queue_tour();
      int n;
      matrix_op_type op;
      n = used_cities(cfg_count);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (!loaded[r][c]) queue_load(CITY_BITS'(r), CITY_BITS'(c), random_distance());
      op.cmd = CMD_RUN;
      op.row = CITY_BITS'($urandom);
      op.col = CITY_BITS'($urandom);
      op.distance = DIST_BITS'($urandom);
      pending_ops.insert(pending_ops.size(), op);
      queued_count++;
   endtask

   // everything accepted and answered, then a drain wait for trailing loads
   task automatic wait_idle();
      while (accepted_count != queued_count || tour_stops_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int phase;
      int n;
      int n_items;
      logic [CNT_BITS-1:0] count_w;
      logic [CNT_BITS-1:0] start_w;
      phase = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: hand-built matrix with a tie, zero and full-scale edges
      write_csr(CSR_CITY_COUNT, CNT_BITS'(4));
      write_csr(CSR_START_CITY, CNT_BITS'(0));
      for (int k = 0; k < 16; k++)
         queue_load(CITY_BITS'(k / 4), CITY_BITS'(k % 4), DIRECTED_DIST[k]);
      queue_tour();
      wait_idle();
      // start city beyond the count falls back to city 0
      write_csr(CSR_START_CITY, CNT_BITS'(5));
      queue_tour();
      wait_idle();
      // counts below two behave as two
      write_csr(CSR_CITY_COUNT, CNT_BITS'(0));
      write_csr(CSR_START_CITY, CNT_BITS'(1));
      queue_tour();
      wait_idle();
      write_csr(CSR_CITY_COUNT, CNT_BITS'(1));
      write_csr(CSR_START_CITY, CNT_BITS'(0));
      queue_tour();
      wait_idle();

      // random phases, each with its own settings and idling
      while (queued_count < TOTAL_ITEMS) begin
         idle_mode = idle_mode_type'(phase % 4);
         case (phase)
            0: count_w = CNT_BITS'(12);
            1: count_w = CNT_BITS'(11);
            2: count_w = CNT_BITS'(1);
            3: count_w = CNT_BITS'(0);
            4: count_w = CNT_BITS'(5);
            default: begin
               case ($urandom_range(0, 9))
                  0:       count_w = CNT_BITS'($urandom_range(0, 1));
                  1, 2:    count_w = CNT_BITS'($urandom_range(9, 12));
                  default: count_w = CNT_BITS'($urandom_range(2, 8));
               endcase
            end
         endcase
         n = used_cities(count_w);
         if ($urandom_range(0, 1)) start_w = CNT_BITS'($urandom_range(0, n - 1));
         else start_w = CNT_BITS'($urandom_range(0, 63));
         write_csr(CSR_CITY_COUNT, count_w);
         write_csr(CSR_START_CITY, start_w);
         // long receiver hold-off while tour requests keep coming
         if (phase == 4) stall_requests++;
         n_items = $urandom_range(6, 16);
         for (int k = 0; k < n_items; k++) begin
            if (phase == 4 || $urandom_range(0, 99) < 35) begin
               queue_tour();
            end else if ($urandom_range(0, 99) < 70) begin
               queue_load(CITY_BITS'($urandom_range(0, n - 1)),
                          CITY_BITS'($urandom_range(0, n - 1)), random_distance());
            end else begin
               queue_load(CITY_BITS'($urandom), CITY_BITS'($urandom), random_distance());
            end
         end
         wait_idle();
         phase++;
      end

      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d matrix loads and %0d tour builds, %0d tour stops checked",
               loads_accepted, tours_accepted, stops_checked);
      $display("over %0d random settings phases, counts from below 2 up to 12, all idle modes",
               phase);
      if (mismatch_count == 0 && tour_stops_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results still expected", mismatch_count,
                  tour_stops_due.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* nearest_neighbour_tour.f */
+incdir+hw/rtl
hw/rtl/nnt_pkg.sv
hw/rtl/nnt_dist_mem.sv
hw/rtl/nnt_tour_seq.sv
hw/rtl/nnt_rsp_reg.sv
hw/rtl/nearest_neighbour_tour.sv
dv/tb_nearest_neighbour_tour.sv
